@@ rtl/rasi_pkg.sv @@
// Shared constants, payload types and helper functions of the ray and segment intersection unit.
`timescale 1ns / 1ps

package rasi_pkg;

    localparam int COORD_BITS = 16;
    localparam int DW         = COORD_BITS + 1;
    localparam int PW         = 2 * DW;
    localparam int NW         = PW + 1;
    localparam int QW         = COORD_BITS + 1;
    localparam int HW         = NW - QW;
    localparam int IN_W       = ((8 * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_W      = ((2 * DW + 7) / 8) * 8;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [DW-1:0]         dcoord_t;
    typedef logic signed [PW-1:0]         prod_t;
    typedef logic signed [NW-1:0]         num_t;

    typedef struct packed {
        logic   hit;
        logic   use_div;
        logic   div_y;
        coord_t fx;
        coord_t fy;
    } meta_t;

    typedef struct packed {
        meta_t   meta;
        logic    coll;
        logic    share_ok;
        logic    inr_ok;
        dcoord_t e1;
        dcoord_t f;
        dcoord_t g;
        dcoord_t h1;
        dcoord_t e2;
        dcoord_t h2;
        dcoord_t den;
        dcoord_t da;
        dcoord_t db;
        coord_t  b1;
    } front_t;

    typedef struct packed {
        meta_t   meta;
        logic    coll;
        logic    share_ok;
        logic    inr_ok;
        prod_t   p1;
        prod_t   p2;
        prod_t   p3;
        prod_t   p4;
        prod_t   pb;
        prod_t   pn;
        dcoord_t den;
    } mult_t;

    typedef struct packed {
        meta_t   meta;
        num_t    num;
        dcoord_t den;
    } sum_t;

    typedef struct packed {
        meta_t          meta;
        logic           neg;
        logic           den_zero;
        logic           ovf;
        logic [DW-1:0]  rem;
        logic [DW-1:0]  dmag;
        logic [QW-1:0]  low;
        logic [QW-1:0]  q;
    } div_t;

    function automatic logic in_range(coord_t v, coord_t a, coord_t b);
        return ((a <= v) && (v <= b)) || ((b <= v) && (v <= a));
    endfunction

    function automatic logic share_point(coord_t a1, coord_t a2, coord_t b1, coord_t b2);
        return in_range(a1, b1, b2) || in_range(a2, b1, b2) ||
               in_range(b1, a1, a2) || in_range(b2, a1, a2);
    endfunction

endpackage

@@ rtl/rasi_front.sv @@
// First pipeline stage: unpacks a beat, takes the comparisons and forms all operand differences.
`timescale 1ns / 1ps

module rasi_front
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [rasi_pkg::IN_W-1:0] in_data,
    input  logic                      in_vertical,
    output logic                      out_valid,
    input  logic                      out_ready,
    output rasi_pkg::front_t          out_data
);
    import rasi_pkg::*;

    coord_t  ox1, oy1, ox2, oy2, rx1, ry1, rx2, ry2;
    coord_t  line, a1, b1, a2, b2;
    logic    pc, noshare;
    coord_t  common_c;
    front_t  stage_next;
    front_t  stage_reg;
    logic    valid_reg;

    assign ox1 = coord_t'(in_data[0*COORD_BITS +: COORD_BITS]);
    assign oy1 = coord_t'(in_data[1*COORD_BITS +: COORD_BITS]);
    assign ox2 = coord_t'(in_data[2*COORD_BITS +: COORD_BITS]);
    assign oy2 = coord_t'(in_data[3*COORD_BITS +: COORD_BITS]);
    assign rx1 = coord_t'(in_data[4*COORD_BITS +: COORD_BITS]);
    assign ry1 = coord_t'(in_data[5*COORD_BITS +: COORD_BITS]);
    assign rx2 = coord_t'(in_data[6*COORD_BITS +: COORD_BITS]);
    assign ry2 = coord_t'(in_data[7*COORD_BITS +: COORD_BITS]);

    always_comb
    begin
        stage_next = '0;
        // The hit test follows the obstacle geometry, not the type flag.
        if (ox1 == ox2)
        begin
            stage_next.coll     = (rx1 == rx2) && (rx1 == ox1);
            stage_next.share_ok = share_point(oy1, oy2, ry1, ry2);
            stage_next.inr_ok   = in_range(ox1, rx1, rx2);
        end
        else
        begin
            stage_next.coll     = (ry1 == ry2) && (ry1 == oy1);
            stage_next.share_ok = share_point(ox1, ox2, rx1, rx2);
            stage_next.inr_ok   = in_range(oy1, ry1, ry2);
        end

        // The point calculation follows the type flag.
        if (in_vertical)
        begin
            pc       = (ox1 == rx1) && (ox2 == rx2);
            noshare  = !((oy1 == ry1) || (oy2 == ry1) || (oy2 == ry2));
            common_c = ((oy1 == ry1) || (oy1 == ry2)) ? oy1 : oy2;
            line = ox1;
            a1   = rx1;
            b1   = ry1;
            a2   = rx2;
            b2   = ry2;
            stage_next.meta.div_y = 1'b1;
            if (!pc)
            begin
                stage_next.meta.fx = ox1;
                stage_next.meta.fy = rx1;
            end
            else if (noshare)
            begin
                stage_next.meta.fx = ox1;
                stage_next.meta.fy = ry1;
            end
            else
            begin
                stage_next.meta.fx = rx1;
                stage_next.meta.fy = common_c;
            end
        end
        else
        begin
            pc       = (oy1 == ry1) && (oy2 == ry2);
            noshare  = !((ox1 == rx1) || (ox2 == rx1) || (ox2 == rx2));
            common_c = ((ox1 == rx1) || (ox1 == rx2)) ? ox1 : ox2;
            line = oy1;
            a1   = ry1;
            b1   = rx1;
            a2   = ry2;
            b2   = rx2;
            stage_next.meta.div_y = 1'b0;
            if (!pc)
            begin
                stage_next.meta.fx = rx1;
                stage_next.meta.fy = oy1;
            end
            else if (noshare)
            begin
                stage_next.meta.fx = rx1;
                stage_next.meta.fy = oy1;
            end
            else
            begin
                stage_next.meta.fx = common_c;
                stage_next.meta.fy = ry1;
            end
        end
        stage_next.meta.use_div = !pc;
        stage_next.meta.hit     = 1'b0;

        stage_next.e1  = dcoord_t'(ox1) - dcoord_t'(rx2);
        stage_next.f   = dcoord_t'(ry1) - dcoord_t'(ry2);
        stage_next.g   = dcoord_t'(rx1) - dcoord_t'(rx2);
        stage_next.h1  = dcoord_t'(oy1) - dcoord_t'(ry2);
        stage_next.e2  = dcoord_t'(ox2) - dcoord_t'(rx2);
        stage_next.h2  = dcoord_t'(oy2) - dcoord_t'(ry2);
        stage_next.den = dcoord_t'(a2) - dcoord_t'(a1);
        stage_next.da  = dcoord_t'(line) - dcoord_t'(a1);
        stage_next.db  = dcoord_t'(b2) - dcoord_t'(b1);
        stage_next.b1  = b1;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = stage_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            stage_reg <= stage_next;
    end

endmodule

@@ rtl/rasi_mult.sv @@
// Second pipeline stage: the cross-product and interpolation multiplications.
`timescale 1ns / 1ps

module rasi_mult
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  rasi_pkg::front_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output rasi_pkg::mult_t  out_data
);
    import rasi_pkg::*;

    mult_t stage_next;
    mult_t stage_reg;
    logic  valid_reg;

    always_comb
    begin
        stage_next.meta     = in_data.meta;
        stage_next.coll     = in_data.coll;
        stage_next.share_ok = in_data.share_ok;
        stage_next.inr_ok   = in_data.inr_ok;
        stage_next.p1       = prod_t'(in_data.e1) * prod_t'(in_data.f);
        stage_next.p2       = prod_t'(in_data.g) * prod_t'(in_data.h1);
        stage_next.p3       = prod_t'(in_data.e2) * prod_t'(in_data.f);
        stage_next.p4       = prod_t'(in_data.g) * prod_t'(in_data.h2);
        stage_next.pb       = prod_t'(in_data.b1) * prod_t'(in_data.den);
        stage_next.pn       = prod_t'(in_data.db) * prod_t'(in_data.da);
        stage_next.den      = in_data.den;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = stage_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            stage_reg <= stage_next;
    end

endmodule

@@ rtl/rasi_resolve.sv @@
// Third and fourth pipeline stages: hit decision, numerator, and divider operand set-up.
`timescale 1ns / 1ps

module rasi_resolve
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  rasi_pkg::mult_t in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output rasi_pkg::div_t  out_data
);
    import rasi_pkg::*;

    num_t          c1, c2;
    logic          same_side;
    sum_t          sum_next;
    sum_t          sum_reg;
    logic          sum_valid_reg;
    logic          sum_ready;
    logic [NW-1:0] nmag;
    logic [HW-1:0] high;
    div_t          div_next;
    div_t          div_reg;
    logic          div_valid_reg;

    always_comb
    begin
        c1 = num_t'(in_data.p1) - num_t'(in_data.p2);
        c2 = num_t'(in_data.p3) - num_t'(in_data.p4);
        // A zero cross product counts as crossing.
        same_side = (c1 != '0) && (c2 != '0) && (c1[NW-1] == c2[NW-1]);
        sum_next.meta     = in_data.meta;
        sum_next.meta.hit = in_data.coll ? in_data.share_ok : (in_data.inr_ok && !same_side);
        sum_next.num      = num_t'(in_data.pb) + num_t'(in_data.pn);
        sum_next.den      = in_data.den;
    end

    always_comb
    begin
        nmag = sum_reg.num[NW-1] ? NW'(-sum_reg.num) : NW'(sum_reg.num);
        high = nmag[NW-1:QW];
        div_next.meta     = sum_reg.meta;
        div_next.neg      = sum_reg.num[NW-1] ^ sum_reg.den[DW-1];
        div_next.den_zero = (sum_reg.den == '0);
        div_next.dmag     = sum_reg.den[DW-1] ? DW'(-sum_reg.den) : DW'(sum_reg.den);
        // The quotient would need more bits than the output keeps: saturate later.
        div_next.ovf      = (high >= HW'(div_next.dmag));
        div_next.rem      = high[DW-1:0];
        div_next.low      = nmag[QW-1:0];
        div_next.q        = '0;
    end

    assign sum_ready = !div_valid_reg || out_ready;
    assign in_ready  = !sum_valid_reg || sum_ready;
    assign out_valid = div_valid_reg;
    assign out_data  = div_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_valid_reg <= 1'b0;
            div_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                sum_valid_reg <= in_valid;
            if (sum_ready)
                div_valid_reg <= sum_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            sum_reg <= sum_next;
        if (sum_ready && sum_valid_reg)
            div_reg <= div_next;
    end

endmodule

@@ rtl/rasi_divider.sv @@
// Pipelined restoring divider of magnitudes, one quotient bit per stage.
`timescale 1ns / 1ps

module rasi_divider
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  rasi_pkg::div_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output rasi_pkg::div_t out_data
);
    import rasi_pkg::*;

    div_t          stg_reg [QW];
    logic [QW-1:0] valid_reg;
    logic [QW-1:0] en;

    function automatic div_t div_step(div_t s);
        logic [DW:0] t;
        logic [DW:0] d;
        logic        ge;
        div_t        r;
        t  = {s.rem, s.low[QW-1]};
        ge = (t >= {1'b0, s.dmag});
        d  = t - {1'b0, s.dmag};
        r      = s;
        r.rem  = ge ? d[DW-1:0] : t[DW-1:0];
        r.low  = {s.low[QW-2:0], 1'b0};
        r.q    = {s.q[QW-2:0], ge};
        return r;
    endfunction

    always_comb
    begin
        en[QW-1] = !valid_reg[QW-1] || out_ready;
        for (int i = QW - 2; i >= 0; i--)
            en[i] = !valid_reg[i] || en[i+1];
    end

    assign in_ready  = en[0];
    assign out_valid = valid_reg[QW-1];
    assign out_data  = stg_reg[QW-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
        begin
            if (en[0])
                valid_reg[0] <= in_valid;
            for (int i = 1; i < QW; i++)
                if (en[i])
                    valid_reg[i] <= valid_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0] && in_valid)
            stg_reg[0] <= div_step(in_data);
        for (int i = 1; i < QW; i++)
            if (en[i] && valid_reg[i-1])
                stg_reg[i] <= div_step(stg_reg[i-1]);
    end

endmodule

@@ rtl/ray_axis_segment_intersect_unit.sv @@
// Top level of the axis-aligned obstacle versus ray segment intersection unit.
`timescale 1ns / 1ps

// One obstacle and ray pair is taken per beat and one result beat leaves for each, in order, at
// a sustained rate of one beat per cycle. The pipeline is one front stage, one multiplier stage,
// two resolve stages, a restoring divider with one quotient bit per stage for the interpolated
// coordinate, and the output register.
// Back-pressure on the result side stalls only as far back as the pipeline is full.
module ray_axis_segment_intersect_unit
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // obstacle_x1, obstacle_y1, obstacle_x2, obstacle_y2, ray_x1, ray_y1, ray_x2, ray_y2
    input  logic [rasi_pkg::IN_W-1:0]  s_tdata,
    // obstacle_vertical
    input  logic                       s_tuser,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // hit_x, hit_y, zero padding
    output logic [rasi_pkg::OUT_W-1:0] m_tdata,
    // hit
    output logic                       m_tuser
);
    import rasi_pkg::*;

    front_t        front_data;
    logic          front_valid, front_ready;
    mult_t         mult_data;
    logic          mult_valid, mult_ready;
    div_t          res_data;
    logic          res_valid, res_ready;
    div_t          dv;
    logic          dv_valid, dv_ready;
    logic [DW-1:0] qval, slot;
    logic          sat;
    dcoord_t       hx, hy;
    logic [OUT_W-1:0] data_next;
    logic [OUT_W-1:0] data_reg;
    logic          hit_reg;
    logic          valid_reg;

    rasi_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_data     (s_tdata),
        .in_vertical (s_tuser),
        .out_valid   (front_valid),
        .out_ready   (front_ready),
        .out_data    (front_data)
    );

    rasi_mult u_mult
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_data   (front_data),
        .out_valid (mult_valid),
        .out_ready (mult_ready),
        .out_data  (mult_data)
    );

    rasi_resolve u_resolve
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mult_valid),
        .in_ready  (mult_ready),
        .in_data   (mult_data),
        .out_valid (res_valid),
        .out_ready (res_ready),
        .out_data  (res_data)
    );

    rasi_divider u_divider
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (res_valid),
        .in_ready  (res_ready),
        .in_data   (res_data),
        .out_valid (dv_valid),
        .out_ready (dv_ready),
        .out_data  (dv)
    );

    always_comb
    begin
        // Truncated quotient with its sign, saturated to the output range.
        if (!dv.neg)
        begin
            sat  = dv.ovf || dv.q[QW-1];
            qval = sat ? {1'b0, {(DW-1){1'b1}}} : DW'(dv.q);
        end
        else
        begin
            sat  = dv.ovf || (dv.q > QW'({1'b1, {(DW-1){1'b0}}}));
            qval = sat ? {1'b1, {(DW-1){1'b0}}} : DW'(-dv.q);
        end

        slot = dv.den_zero ? (dv.meta.div_y ? DW'(dcoord_t'(dv.meta.fy))
                                            : DW'(dcoord_t'(dv.meta.fx)))
                           : qval;
        hx = dcoord_t'(dv.meta.fx);
        hy = dcoord_t'(dv.meta.fy);
        if (dv.meta.use_div)
        begin
            if (dv.meta.div_y)
                hy = dcoord_t'(slot);
            else
                hx = dcoord_t'(slot);
        end
        if (!dv.meta.hit)
        begin
            hx = '0;
            hy = '0;
        end
        data_next = OUT_W'({hy, hx});
    end

    assign dv_ready = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = hit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (dv_ready)
            valid_reg <= dv_valid;
    end

    always_ff @(posedge clk)
    begin
        if (dv_ready && dv_valid)
        begin
            data_reg <= data_next;
            hit_reg  <= dv.meta.hit;
        end
    end

`ifndef SYNTHESIS
    // A miss carries zero coordinates.
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("miss beat with non-zero coordinates");

    // With the result side ready the whole pipeline moves, so the input side is ready too.
    a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
        else $error("input stalled while the result side was ready");

    // A division that did not overflow leaves a remainder below the divisor.
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (dv_valid && !dv.ovf && !dv.den_zero) |-> (dv.rem < dv.dmag))
        else $error("divider remainder not below divisor");
`endif

endmodule
